[sv/crg_pkg.sv]
// Shared types, widths and constants for the camera ray direction generator.
// No dependencies; every other file in this folder imports this package.
package crg_pkg;

	// Fixed-point format of the unit vector and of the axis lanes.
	localparam int FRAC_BITS = 14;
	localparam int MAX_DIM   = 4096;

	// Field and register widths.
	localparam int PIX_W  = 12;
	localparam int DIM_W  = 13;
	localparam int AXIS_W = 48;
	localparam int LANE_W = 16;
	localparam int DIR_W  = 16;
	localparam int IDX_W  = 3;

	// Internal datapath widths.  The clamped divisors keep every camera-space
	// magnitude below 2^25, so no common pre-shift is ever needed.
	localparam int ABS_W  = DIM_W;
	localparam int MAG_W  = 2 * DIM_W - 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W  = ROOT_W + 1;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int DIVD_W = MAG_W + QUO_W;
	localparam int DREM_W = ROOT_W;
	localparam int UNIT_W = FRAC_BITS + 2;
	localparam int PROD_W = UNIT_W + LANE_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int RQ_W   = ACC_W - FRAC_BITS;

	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic [RQ_W-1:0]  POS_LIMIT  = RQ_W'(32767);
	localparam logic [RQ_W-1:0]  NEG_LIMIT  = RQ_W'(32768);

	// Register reset values.
	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = DIM_W'(640);
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = DIM_W'(480);
	localparam logic [AXIS_W-1:0] RST_RIGHT_AXIS   = AXIS_W'(1) << FRAC_BITS;
	localparam logic [AXIS_W-1:0] RST_UP_AXIS      = AXIS_W'(1) << (FRAC_BITS + 16);
	localparam logic [AXIS_W-1:0] RST_BACK_AXIS    = AXIS_W'(1) << (FRAC_BITS + 32);

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_RIGHT_AXIS   = 3'd2,
		REG_UP_AXIS      = 3'd3,
		REG_BACK_AXIS    = 3'd4
	} crg_reg_t;

	// Data carried alongside the squared sum until the root is known.
	typedef struct packed {
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic [MAG_W-1:0] mag_z;
		logic             neg_x;
		logic             neg_y;
	} crg_side_t;

	// A divisor of zero is taken as one and one above MAX_DIM as MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[sv/crg_front.sv]
// Front end: screen coordinates, camera-space magnitudes, squares and their sum.
// Depends on crg_pkg.
module crg_front import crg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PIX_W-1:0]        pixel_col,
	input  logic [PIX_W-1:0]        pixel_row,
	input  logic [DIM_W-1:0]        img_w,
	input  logic [DIM_W-1:0]        img_h,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SUM_W-1:0]        out_sum,
	output crg_side_t               out_side
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [ABS_W-1:0] absx_s1, absy_s1;
	logic             negx_s1, negy_s1;
	crg_side_t        side_s2, side_s3, side_s4;
	logic [SQ_W-1:0]  sqx_s3, sqy_s3, sqz_s3;
	logic [SUM_W-1:0] sum_s4;

	logic signed [ABS_W:0] xs, ys;
	logic [ABS_W:0]        xs_abs, ys_abs;
	logic [2*DIM_W-1:0]    px, py, pz;

	// A stage takes new data when it is empty or its contents move on.
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Offset coordinates 2*col - W and 2*row - H, split into sign and magnitude.
	assign xs     = $signed({1'b0, pixel_col, 1'b0}) - $signed({1'b0, img_w});
	assign ys     = $signed({1'b0, pixel_row, 1'b0}) - $signed({1'b0, img_h});
	assign xs_abs = xs[ABS_W] ? (ABS_W+1)'(-xs) : xs;
	assign ys_abs = ys[ABS_W] ? (ABS_W+1)'(-ys) : ys;

	// Scaled magnitudes |X| = |xs|*H, |Y| = |ys|*W and |Z| = W*H.
	assign px = absx_s1 * img_h;
	assign py = absy_s1 * img_w;
	assign pz = img_w * img_h;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			absx_s1 <= xs_abs[ABS_W-1:0];
			absy_s1 <= ys_abs[ABS_W-1:0];
			negx_s1 <= xs[ABS_W];
			negy_s1 <= ys[ABS_W];
		end
		if (rdy_s2) begin
			side_s2.mag_x <= px[MAG_W-1:0];
			side_s2.mag_y <= py[MAG_W-1:0];
			side_s2.mag_z <= pz[MAG_W-1:0];
			side_s2.neg_x <= negx_s1;
			side_s2.neg_y <= negy_s1;
		end
		if (rdy_s3) begin
			sqx_s3  <= side_s2.mag_x * side_s2.mag_x;
			sqy_s3  <= side_s2.mag_y * side_s2.mag_y;
			sqz_s3  <= side_s2.mag_z * side_s2.mag_z;
			side_s3 <= side_s2;
		end
		if (rdy_s4) begin
			sum_s4  <= SUM_W'(sqx_s3) + SUM_W'(sqy_s3) + SUM_W'(sqz_s3);
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_sum   = sum_s4;
	assign out_side  = side_s4;

endmodule

[sv/crg_sqrt.sv]
// Pipelined integer square root, one root bit per stage, with sideband data.
// Depends on crg_pkg.
module crg_sqrt import crg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [SUM_W-1:0]   in_sum,
	input  crg_side_t          in_side,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROOT_W-1:0]  out_root,
	output crg_side_t          out_side
);

	localparam int N = ROOT_W;

	logic              v_s    [N];
	logic [REM_W-1:0]  rem_s  [N];
	logic [ROOT_W-1:0] root_s [N];
	logic [SUM_W-1:0]  rad_s  [N];
	crg_side_t         side_s [N];
	logic              rdy    [N+1];

	// Ready chain from the output back to the input.
	always_comb begin
		rdy[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[0];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic              prev_v;
		logic [REM_W-1:0]  prev_rem;
		logic [ROOT_W-1:0] prev_root;
		logic [SUM_W-1:0]  prev_rad;
		crg_side_t         prev_side;
		logic [REM_W+1:0]  ext;
		logic [REM_W+1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign prev_v    = in_valid;
			assign prev_rem  = '0;
			assign prev_root = '0;
			assign prev_rad  = in_sum;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_v    = v_s[k-1];
			assign prev_rem  = rem_s[k-1];
			assign prev_root = root_s[k-1];
			assign prev_rad  = rad_s[k-1];
			assign prev_side = side_s[k-1];
		end

		// Bring down the next two radicand bits and try root*4 + 1.
		assign ext   = {prev_rem, prev_rad[SUM_W-1 -: 2]};
		assign trial = (REM_W+2)'({prev_root, 2'b01});
		assign take  = ext >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k]  <= take ? REM_W'(ext - trial) : REM_W'(ext);
				root_s[k] <= {prev_root[ROOT_W-2:0], take};
				rad_s[k]  <= {prev_rad[SUM_W-3:0], 2'b00};
				side_s[k] <= prev_side;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

[sv/crg_div.sv]
// Pipelined rounded division of the three magnitudes by the root, one
// quotient bit per stage on three lanes.  Depends on crg_pkg.
module crg_div import crg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ROOT_W-1:0] in_root,
	input  crg_side_t         in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [QUO_W-1:0]  out_quo [3],
	output logic              out_neg_x,
	output logic              out_neg_y
);

	localparam int N = QUO_W + 1;

	logic              v_s    [N];
	logic [DREM_W-1:0] rem_s  [N][3];
	logic [QUO_W-1:0]  low_s  [N][3];
	logic [QUO_W-1:0]  quo_s  [N][3];
	logic [ROOT_W-1:0] dvs_s  [N];
	logic              negx_s [N];
	logic              negy_s [N];
	logic              rdy    [N+1];

	logic [MAG_W-1:0]  mags [3];
	logic [DIVD_W-1:0] dvd  [3];

	// Ready chain from the output back to the input.
	always_comb begin
		rdy[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[0];

	// Dividend mag * 2^FRAC_BITS + floor(root / 2) gives round to nearest.
	assign mags[0] = in_side.mag_x;
	assign mags[1] = in_side.mag_y;
	assign mags[2] = in_side.mag_z;
	for (genvar l = 0; l < 3; l++) begin : g_dvd
		assign dvd[l] = DIVD_W'({mags[l], {FRAC_BITS{1'b0}}}) + DIVD_W'(in_root >> 1);
	end

	// Set-up stage: high dividend part is already below the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= DREM_W'(dvd[l][DIVD_W-1:QUO_W]);
				low_s[0][l] <= dvd[l][QUO_W-1:0];
				quo_s[0][l] <= '0;
			end
			dvs_s[0]  <= in_root;
			negx_s[0] <= in_side.neg_x;
			negy_s[0] <= in_side.neg_y;
		end
	end

	// Restoring division stages.
	for (genvar k = 1; k < N; k++) begin : g_stage
		logic [DREM_W:0] ext  [3];
		logic            take [3];

		for (genvar l = 0; l < 3; l++) begin : g_lane
			assign ext[l]  = {rem_s[k-1][l], low_s[k-1][l][QUO_W-1]};
			assign take[l] = ext[l] >= {1'b0, dvs_s[k-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[k][l] <= take[l] ? DREM_W'(ext[l] - {1'b0, dvs_s[k-1]})
						: DREM_W'(ext[l]);
					low_s[k][l] <= {low_s[k-1][l][QUO_W-2:0], 1'b0};
					quo_s[k][l] <= {quo_s[k-1][l][QUO_W-2:0], take[l]};
				end
				dvs_s[k]  <= dvs_s[k-1];
				negx_s[k] <= negx_s[k-1];
				negy_s[k] <= negy_s[k-1];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_quo   = quo_s[N-1];
	assign out_neg_x = negx_s[N-1];
	assign out_neg_y = negy_s[N-1];

endmodule

[sv/crg_rot.sv]
// Rotation into world space: nine products, three sums, then rounding and
// saturation into the output register.  Depends on crg_pkg.
module crg_rot import crg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [QUO_W-1:0]         in_quo [3],
	input  logic                     in_neg_x,
	input  logic                     in_neg_y,
	input  logic [AXIS_W-1:0]        right_axis,
	input  logic [AXIS_W-1:0]        up_axis,
	input  logic [AXIS_W-1:0]        back_axis,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DIR_W-1:0]  out_dir [3]
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [ACC_W-1:0]  acc_s2  [3];
	logic signed [DIR_W-1:0]  dir_s3  [3];

	logic signed [UNIT_W-1:0] unit [3];
	logic [AXIS_W-1:0]        axes [3];
	logic [ACC_W-1:0]         mag  [3];
	logic [RQ_W-1:0]          rq   [3];
	logic signed [DIR_W-1:0]  sat  [3];

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Signed unit components; the camera-space z is always negative.
	assign unit[0] = in_neg_x ? -$signed(UNIT_W'(in_quo[0])) : $signed(UNIT_W'(in_quo[0]));
	assign unit[1] = in_neg_y ? -$signed(UNIT_W'(in_quo[1])) : $signed(UNIT_W'(in_quo[1]));
	assign unit[2] = -$signed(UNIT_W'(in_quo[2]));

	assign axes[0] = right_axis;
	assign axes[1] = up_axis;
	assign axes[2] = back_axis;

	// Round half away from zero, then saturate to the output range.
	for (genvar j = 0; j < 3; j++) begin : g_out
		assign mag[j] = acc_s2[j][ACC_W-1] ? ACC_W'(-acc_s2[j]) : ACC_W'(acc_s2[j]);
		assign rq[j]  = RQ_W'((mag[j] + ROUND_HALF) >> FRAC_BITS);
		always_comb begin
			if (acc_s2[j][ACC_W-1]) begin
				sat[j] = (rq[j] > NEG_LIMIT) ? DIR_W'(NEG_LIMIT) : DIR_W'(-rq[j]);
			end else begin
				sat[j] = (rq[j] > POS_LIMIT) ? DIR_W'(POS_LIMIT) : DIR_W'(rq[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s1[j][i] <= unit[i] * $signed(axes[i][LANE_W*j +: LANE_W]);
				end
			end
		end
		if (rdy_s2) begin
			for (int j = 0; j < 3; j++) begin
				acc_s2[j] <= ACC_W'(prod_s1[j][0]) + ACC_W'(prod_s1[j][1])
					+ ACC_W'(prod_s1[j][2]);
			end
		end
		if (rdy_s3) begin
			for (int j = 0; j < 3; j++) begin
				dir_s3[j] <= sat[j];
			end
		end
	end

	assign out_valid = v_s3;
	assign out_dir   = dir_s3;

endmodule

[sv/camera_ray_direction_generator_unit.sv]
// Top level of the pinhole camera ray direction generator.
// Depends on crg_pkg, crg_front, crg_sqrt, crg_div and crg_rot.
//
//   Channel   Handshake            Payload
//   --------  -------------------  -----------------------------------
//   input     in_valid / in_ready  pixel_col, pixel_row
//   output    out_valid/ out_ready dir_x, dir_y, dir_z
//   config    cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One pixel enters per cycle unless a stalled output fills the pipeline.
// Stages: 4 front-end, 26 square-root, 16 divider and 3 rotation.
// Every stage has its own valid bit and loads when empty or draining, so a
// stalled output fills the bubbles before the input is held back.
// Reset clears all valid bits and loads the default image size and axes.
// Configuration writes are taken in every cycle.
module camera_ray_direction_generator_unit import crg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PIX_W-1:0]        pixel_col,
	input  logic [PIX_W-1:0]        pixel_row,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DIR_W-1:0] dir_x,
	output logic signed [DIR_W-1:0] dir_y,
	output logic signed [DIR_W-1:0] dir_z,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [AXIS_W-1:0]       cfg_data
);

	logic [DIM_W-1:0]  width_q, height_q;
	logic [AXIS_W-1:0] right_q, up_q, back_q;

	logic              fr_valid, fr_ready;
	logic [SUM_W-1:0]  fr_sum;
	crg_side_t         fr_side;
	logic              sq_valid, sq_ready;
	logic [ROOT_W-1:0] sq_root;
	crg_side_t         sq_side;
	logic              dv_valid, dv_ready;
	logic [QUO_W-1:0]  dv_quo [3];
	logic              dv_neg_x, dv_neg_y;
	logic signed [DIR_W-1:0] dirs [3];

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			right_q  <= RST_RIGHT_AXIS;
			up_q     <= RST_UP_AXIS;
			back_q   <= RST_BACK_AXIS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_RIGHT_AXIS:   right_q  <= cfg_data;
				REG_UP_AXIS:      up_q     <= cfg_data;
				REG_BACK_AXIS:    back_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	crg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.img_w     (clamp_dim(width_q)),
		.img_h     (clamp_dim(height_q)),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_sum   (fr_sum),
		.out_side  (fr_side)
	);

	crg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_sum    (fr_sum),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	crg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_quo   (dv_quo),
		.out_neg_x (dv_neg_x),
		.out_neg_y (dv_neg_y)
	);

	crg_rot u_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (dv_valid),
		.in_ready   (dv_ready),
		.in_quo     (dv_quo),
		.in_neg_x   (dv_neg_x),
		.in_neg_y   (dv_neg_y),
		.right_axis (right_q),
		.up_axis    (up_q),
		.back_axis  (back_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_dir    (dirs)
	);

	assign dir_x = dirs[0];
	assign dir_y = dirs[1];
	assign dir_z = dirs[2];

endmodule

[sv/crg_checker.sv]
// Port-level checker for the camera ray direction generator, bound to the top.
// Depends on crg_pkg and camera_ray_direction_generator_unit.
module crg_checker import crg_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [DIR_W-1:0] dir_x,
	input logic                    cfg_ready
);

	// A waiting result stays offered and keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dir_x))
		else $error("result withdrawn or changed before the transaction completed");

	// A pixel that has been offered stays offered until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("pixel withdrawn before the transaction completed");

	// An empty or draining output stage never holds the input back.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while the pipeline can move");

	// Reset empties the pipeline.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered during reset");

	// Register writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready && $stable(cfg_ready))
		else $error("configuration transaction refused");

endmodule

bind camera_ray_direction_generator_unit crg_checker u_crg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.dir_x     (dir_x),
	.cfg_ready (cfg_ready)
);

[tb/camera_ray_direction_generator_unit_test.sv]
// Self-checking testbench for camera_ray_direction_generator_unit.
// Depends on crg_pkg and the RTL; an internal ray predictor checks each result in order.
`timescale 1ns / 1ps

module camera_ray_direction_generator_unit_test;
	import crg_pkg::*;

	// A direction triple predicted for one pixel.
	typedef struct {
		logic signed [DIR_W-1:0] x;
		logic signed [DIR_W-1:0] y;
		logic signed [DIR_W-1:0] z;
	} ray_t;

	// Holds the predicted rays and compares arriving ones against them.
	class ray_scoreboard;
		ray_t pending[$];
		int unsigned errors;
		logic [DIM_W-1:0] width_reg, height_reg;
		logic [AXIS_W-1:0] axes[3];

		function void reset_regs();
			width_reg = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			axes[0] = RST_RIGHT_AXIS;
			axes[1] = RST_UP_AXIS;
			axes[2] = RST_BACK_AXIS;
		endfunction

		function void write_reg(input logic [IDX_W-1:0] idx, input logic [AXIS_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH:  width_reg = val[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_reg = val[DIM_W-1:0];
				REG_RIGHT_AXIS:   axes[0] = val;
				REG_UP_AXIS:      axes[1] = val;
				REG_BACK_AXIS:    axes[2] = val;
				default: ;
			endcase
		endfunction

		// Predicts the ray of one accepted pixel and queues it.
		function void note_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
			longint w, h, xs, ys, biggest, sum, root, rem, acc, m, q;
			longint mag[3], unit[3];
			bit neg[3];
			int k;
			ray_t ray;
			longint outv[3];
			w = (width_reg == 0) ? 1 : (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
			h = (height_reg == 0) ? 1 : (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
			xs = 2 * longint'(col) - w;
			ys = 2 * longint'(row) - h;
			neg[0] = xs < 0;
			neg[1] = ys < 0;
			neg[2] = 1;
			mag[0] = (xs < 0 ? -xs : xs) * h;
			mag[1] = (ys < 0 ? -ys : ys) * w;
			mag[2] = w * h;
			biggest = mag[0];
			if (mag[1] > biggest) biggest = mag[1];
			if (mag[2] > biggest) biggest = mag[2];
			k = 0;
			while ((biggest >> k) >= (longint'(1) << 26)) k++;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = mag[i] >> k;
				sum += mag[i] * mag[i];
			end
			// Integer square root by bisection of the floor.
			root = 0;
			for (int b = 30; b >= 0; b--) begin
				rem = root | (longint'(1) << b);
				if (rem * rem <= sum) root = rem;
			end
			if (root == 0) root = 1;
			for (int i = 0; i < 3; i++) begin
				q = ((mag[i] << FRAC_BITS) + (root >> 1)) / root;
				unit[i] = neg[i] ? -q : q;
			end
			// Rotate into world space, round half away from zero and saturate.
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int a = 0; a < 3; a++)
					acc += unit[a] * longint'($signed(axes[a][16*j +: 16]));
				m = acc < 0 ? -acc : acc;
				q = (m + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
				if (acc < 0) outv[j] = (q > 32768) ? -32768 : -q;
				else outv[j] = (q > 32767) ? 32767 : q;
			end
			ray.x = outv[0][15:0];
			ray.y = outv[1][15:0];
			ray.z = outv[2][15:0];
			pending.insert(pending.size(), ray);
		endfunction

		// Compares one arriving ray with the oldest prediction.
		function void check_ray(input logic signed [DIR_W-1:0] x, y, z);
			ray_t e;
			if (pending.size() == 0) begin
				$error("unexpected ray %0d %0d %0d", x, y, z);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (x !== e.x) begin
				$error("dir_x expected %0d actual %0d", e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$error("dir_y expected %0d actual %0d", e.y, y);
				errors++;
			end
			if (z !== e.z) begin
				$error("dir_z expected %0d actual %0d", e.z, z);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY = 49;
	localparam longint CYCLE_LIMIT = 400000;
	// An index beyond the register list; writes to it are ignored.
	localparam crg_reg_t REG_PAST_END = crg_reg_t'(3'd7);

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [PIX_W-1:0] pixel_col = '0;
	logic [PIX_W-1:0] pixel_row = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [AXIS_W-1:0] cfg_data = '0;

	ray_scoreboard rays = new();
	int send_idle = 0;
	int recv_idle = 0;
	longint cycles = 0;

	camera_ray_direction_generator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_col(pixel_col), .pixel_row(pixel_row),
		.out_valid(out_valid), .out_ready(out_ready),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock with a period of 4 ns.
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("camera_ray_direction_generator_unit_test: errors");
			$finish;
		end
	end

	// Receiver: checks each output transaction and stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				rays.check_ray(dir_x, dir_y, dir_z);
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Writes one configuration register while the block is idle.
	task automatic write_cfg(input crg_reg_t idx, input logic [AXIS_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		rays.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Sends one pixel transaction, with a random gap before it.
	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		pixel_col <= col;
		pixel_row <= row;
		do @(posedge clk); while (!in_ready);
		rays.note_pixel(col, row);
	endtask

	// Lowers valid and waits for every predicted ray to arrive.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (rays.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Random axis lane, biased to a few interesting values.
	function automatic logic [15:0] rand_lane();
		case ($urandom_range(5))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_axes();
		write_cfg(REG_RIGHT_AXIS, {rand_lane(), rand_lane(), rand_lane()});
		write_cfg(REG_UP_AXIS, {rand_lane(), rand_lane(), rand_lane()});
		write_cfg(REG_BACK_AXIS, {rand_lane(), rand_lane(), rand_lane()});
	endtask

	task automatic random_pixels(input int count);
		logic [PIX_W-1:0] c, r;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				c = PIX_W'($urandom);
				r = PIX_W'($urandom);
			end else begin
				c = PIX_W'($urandom_range(rays.width_reg == 0 ? 0 : rays.width_reg - 1));
				r = PIX_W'($urandom_range(rays.height_reg == 0 ? 0 : rays.height_reg - 1));
			end
			send_pixel(c, r);
		end
	endtask

	initial begin
		rays.reset_regs();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: two corners, the centre and out-of-image pixels at reset settings.
		send_idle = 6;
		recv_idle = 61;
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd639, 12'd479);
		send_pixel(12'd320, 12'd240);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		drain();

		// Zero divisors, oversized divisors and out-of-image pixels.
		write_cfg(REG_IMAGE_WIDTH, AXIS_W'(0));
		write_cfg(REG_IMAGE_HEIGHT, AXIS_W'(0));
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd1);
		drain();
		write_cfg(REG_IMAGE_WIDTH, 48'h1FFF);
		write_cfg(REG_IMAGE_HEIGHT, 48'h1FFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd2048);
		drain();

		// Non-orthonormal axes that saturate, and an index past the list.
		write_cfg(REG_IMAGE_WIDTH, AXIS_W'(1));
		write_cfg(REG_IMAGE_HEIGHT, AXIS_W'(4096));
		write_cfg(REG_RIGHT_AXIS, 48'h7FFF_7FFF_7FFF);
		write_cfg(REG_UP_AXIS, 48'h8000_8000_8000);
		write_cfg(REG_BACK_AXIS, 48'h7FFF_8000_7FFF);
		write_cfg(REG_PAST_END, 48'hFFFF_FFFF_FFFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd1, 12'd2048);
		drain();

		// Random part: three idling phases, several settings in each.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 6 : (phase == 1) ? 61 : 0;
			recv_idle = (phase == 0) ? 61 : (phase == 1) ? 6 : 0;
			for (int s = 0; s < 4; s++) begin
				case ($urandom_range(3))
					0: write_cfg(REG_IMAGE_WIDTH, AXIS_W'(4096));
					1: write_cfg(REG_IMAGE_WIDTH, AXIS_W'($urandom_range(1, 64)));
					default: write_cfg(REG_IMAGE_WIDTH, AXIS_W'($urandom_range(8191)));
				endcase
				case ($urandom_range(3))
					0: write_cfg(REG_IMAGE_HEIGHT, AXIS_W'(1));
					1: write_cfg(REG_IMAGE_HEIGHT, AXIS_W'($urandom_range(1, 64)));
					default: write_cfg(REG_IMAGE_HEIGHT, AXIS_W'($urandom_range(8191)));
				endcase
				random_axes();
				random_pixels(162);
				drain();
			end
		end

		if (rays.errors == 0)
			$display("camera_ray_direction_generator_unit_test: clean");
		else
			$display("camera_ray_direction_generator_unit_test: errors");
		$finish;
	end

endmodule
